### rtl/srlt_pkg.sv
// Package with shared types and codes for the shared/exclusive range lock table.
package srlt_pkg;

  typedef enum logic [1:0] {
    CMD_LOCK_SHARED   = 2'd0,
    CMD_LOCK_EXCL     = 2'd1,
    CMD_UNLOCK_SHARED = 2'd2,
    CMD_UNLOCK_EXCL   = 2'd3
  } cmd_t;

  typedef logic [1:0] status_t;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_BUSY  = 2'd1;
  localparam status_t ST_RANGE = 2'd2;

  localparam int FIRST_BITS = 3;
  localparam int COUNT_FIELD_BITS = 4;
  localparam int RANGE_BITS = 6;

  typedef struct packed {
    cmd_t                        cmd;
    logic [FIRST_BITS-1:0]       first_slot;
    logic [COUNT_FIELD_BITS-1:0] slot_count;
  } req_t;

endpackage

### rtl/shared_exclusive_range_lock_table.sv
// Top level of the shared/exclusive range lock table: request and result registers.
// Each request names a command and a slot range and yields one status (ok, busy, or
// out of bounds). A request is captured in the input register, checked and applied to
// all slots at once while the result register is free, and its status lands in the
// result register; one request is taken every cycle as long as the result side keeps
// up. The single pass over the slot array sets the rate; state updates land before the
// following request is checked.
module shared_exclusive_range_lock_table
  import srlt_pkg::*;
#(
  parameter int NUM_SLOTS  = 8,
  parameter int COUNT_BITS = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  cmd,
  input  logic [FIRST_BITS-1:0]       first_slot,
  input  logic [COUNT_FIELD_BITS-1:0] slot_count,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  status
);

  logic    req_valid;
  req_t    req;
  logic    out_free;
  logic    fire;
  status_t status_next;

  assign out_free = !out_valid || !out_stall;
  assign fire     = req_valid && out_free;
  assign in_stall = req_valid && !out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!in_stall) begin
      req_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      req.cmd        <= cmd_t'(cmd);
      req.first_slot <= first_slot;
      req.slot_count <= slot_count;
    end
  end

  srlt_slot_array #(
    .NUM_SLOTS  (NUM_SLOTS),
    .COUNT_BITS (COUNT_BITS)
  ) u_slots (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .req    (req),
    .status (status_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      status <= status_next;
    end
  end

  a_fire_gives_result: assert property (@(posedge clk) disable iff (rst)
    fire |=> out_valid)
    else $error("processed transaction produced no result");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> req_valid && out_valid)
    else $error("input stalled with a free pipeline");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status == ST_OK || status == ST_BUSY || status == ST_RANGE)
    else $error("result holds an undefined status");

endmodule

### rtl/srlt_slot_array.sv
// Lock slot state with parallel range check and per-slot update.
module srlt_slot_array
  import srlt_pkg::*;
#(
  parameter int NUM_SLOTS  = 8,
  parameter int COUNT_BITS = 8
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    fire,
  input  req_t    req,
  output status_t status
);

  localparam logic [RANGE_BITS-1:0] SlotLimit = RANGE_BITS'(NUM_SLOTS);

  logic [COUNT_BITS-1:0] counts [NUM_SLOTS];
  logic [NUM_SLOTS-1:0]  marks;
  logic [NUM_SLOTS-1:0]  mask;
  logic [NUM_SLOTS-1:0]  nonzero;
  logic [RANGE_BITS-1:0] first_ext;
  logic [RANGE_BITS-1:0] last;
  logic                  range_bad;
  logic                  conflict;
  logic                  commit;

  assign first_ext = RANGE_BITS'(req.first_slot);
  assign last      = first_ext + RANGE_BITS'(req.slot_count);
  assign range_bad = last > SlotLimit;

  genvar i;
  generate
    for (i = 0; i < NUM_SLOTS; i++) begin : g_slot
      localparam logic [RANGE_BITS-1:0] Idx = RANGE_BITS'(i);

      assign mask[i]    = !range_bad && (Idx >= first_ext) && (Idx < last);
      assign nonzero[i] = counts[i] != '0;

      always_ff @(posedge clk) begin
        if (rst) begin
          counts[i] <= '0;
          marks[i]  <= 1'b0;
        end else if (commit && mask[i]) begin
          case (req.cmd)
            CMD_LOCK_SHARED: begin
              if (counts[i] != '1) counts[i] <= counts[i] + 1'b1;
            end
            CMD_LOCK_EXCL: begin
              marks[i] <= 1'b1;
            end
            CMD_UNLOCK_SHARED: begin
              if (nonzero[i]) counts[i] <= counts[i] - 1'b1;
            end
            CMD_UNLOCK_EXCL: begin
              marks[i] <= 1'b0;
            end
            default: begin
              marks[i] <= marks[i];
            end
          endcase
        end
      end
    end
  endgenerate

  always_comb begin
    case (req.cmd)
      CMD_LOCK_SHARED: conflict = |(mask & marks);
      CMD_LOCK_EXCL:   conflict = |(mask & (marks | nonzero));
      default:         conflict = 1'b0;
    endcase
  end

  assign commit = fire && !range_bad && !conflict;

  always_comb begin
    if (range_bad) begin
      status = ST_RANGE;
    end else if (conflict) begin
      status = ST_BUSY;
    end else begin
      status = ST_OK;
    end
  end

  a_excl_grant_marks: assert property (@(posedge clk) disable iff (rst)
    fire && req.cmd == CMD_LOCK_EXCL && status == ST_OK
    |=> (marks & $past(mask)) == $past(mask))
    else $error("exclusive grant left a slot unmarked");

  a_excl_release_clears: assert property (@(posedge clk) disable iff (rst)
    fire && req.cmd == CMD_UNLOCK_EXCL |=> (marks & $past(mask)) == '0)
    else $error("exclusive unlock left a slot marked");

  a_reject_holds_marks: assert property (@(posedge clk) disable iff (rst)
    fire && status != ST_OK |=> $stable(marks))
    else $error("rejected transaction changed exclusive marks");

  a_range_empty_mask: assert property (@(posedge clk) disable iff (rst)
    range_bad |-> mask == '0)
    else $error("out of bounds range selected slots");

endmodule

### tb/tb.sv
// Testbench for the shared/exclusive range lock table: directed, saturation and random requests.
`timescale 1ns / 1ps

module tb;
  import srlt_pkg::*;

  localparam int NUM_SLOTS   = 8;
  localparam int COUNT_BITS  = 8;
  localparam int COUNT_TOP   = (1 << COUNT_BITS) - 1;
  localparam int CYCLE_LIMIT = 200000;

  logic                        clk        = 1'b0;
  logic                        rst        = 1'b1;
  logic                        in_valid   = 1'b0;
  logic                        in_stall;
  cmd_t                        cmd        = CMD_LOCK_SHARED;
  logic [FIRST_BITS-1:0]       first_slot = '0;
  logic [COUNT_FIELD_BITS-1:0] slot_count = '0;
  logic                        out_valid;
  logic                        out_stall  = 1'b0;
  status_t                     status;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int errors         = 0;
  int cycles         = 0;

  logic [COUNT_BITS-1:0] holder_count [NUM_SLOTS];
  logic                  excl_mark [NUM_SLOTS];
  status_t               pending_status [$];
  status_t               want_status;

  shared_exclusive_range_lock_table #(
    .NUM_SLOTS (NUM_SLOTS),
    .COUNT_BITS(COUNT_BITS)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cmd       (cmd),
    .first_slot(first_slot),
    .slot_count(slot_count),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t ns: %s", $realtime, what);
    errors++;
  endtask

  function automatic status_t apply_lock_request(cmd_t c, int first, int n);
    int last;
    bit conflict;
    last = first + n;
    conflict = 1'b0;
    if (last > NUM_SLOTS) return ST_RANGE;
    case (c)
      CMD_LOCK_SHARED: begin
        for (int i = first; i < last; i++) if (excl_mark[i]) conflict = 1'b1;
        if (!conflict)
          for (int i = first; i < last; i++)
            if (holder_count[i] != COUNT_TOP) holder_count[i]++;
      end
      CMD_LOCK_EXCL: begin
        for (int i = first; i < last; i++)
          if (holder_count[i] != 0 || excl_mark[i]) conflict = 1'b1;
        if (!conflict)
          for (int i = first; i < last; i++) excl_mark[i] = 1'b1;
      end
      CMD_UNLOCK_SHARED: begin
        for (int i = first; i < last; i++)
          if (holder_count[i] != 0) holder_count[i]--;
      end
      default: begin
        for (int i = first; i < last; i++) excl_mark[i] = 1'b0;
      end
    endcase
    return conflict ? ST_BUSY : ST_OK;
  endfunction

  task automatic send_request(cmd_t c, int first, int n);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    cmd        <= c;
    first_slot <= first[FIRST_BITS-1:0];
    slot_count <= n[COUNT_FIELD_BITS-1:0];
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
    pending_status.push_back(apply_lock_request(c, first, n));
  endtask

  always @(negedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_status.size() == 0) begin
        report_mismatch($sformatf("status %0d with no request outstanding", status));
      end else begin
        want_status = pending_status.pop_front();
        if (status !== want_status)
          report_mismatch($sformatf("status %0d, predicted %0d", status, want_status));
      end
    end
  end

  task automatic test_directed();
    send_request(CMD_LOCK_SHARED, 7, 2);
    send_request(CMD_LOCK_EXCL, 0, 15);
    send_request(CMD_UNLOCK_SHARED, 1, 8);
    send_request(CMD_LOCK_EXCL, 5, 0);
    send_request(CMD_LOCK_SHARED, 0, 8);
    send_request(CMD_LOCK_EXCL, 3, 1);
    send_request(CMD_LOCK_SHARED, 2, 3);
    send_request(CMD_UNLOCK_EXCL, 2, 3);
    send_request(CMD_UNLOCK_SHARED, 0, 8);
    send_request(CMD_LOCK_EXCL, 2, 1);
    send_request(CMD_UNLOCK_SHARED, 2, 3);
    send_request(CMD_UNLOCK_SHARED, 0, 8);
    send_request(CMD_LOCK_EXCL, 0, 8);
    send_request(CMD_LOCK_SHARED, 7, 1);
    send_request(CMD_LOCK_EXCL, 4, 2);
    send_request(CMD_UNLOCK_SHARED, 0, 8);
    send_request(CMD_UNLOCK_EXCL, 0, 4);
    send_request(CMD_LOCK_SHARED, 0, 4);
    send_request(CMD_LOCK_SHARED, 3, 2);
    send_request(CMD_UNLOCK_EXCL, 4, 4);
    send_request(CMD_UNLOCK_EXCL, 4, 4);
    send_request(CMD_LOCK_EXCL, 7, 1);
    send_request(CMD_UNLOCK_EXCL, 7, 1);
    send_request(CMD_UNLOCK_SHARED, 0, 4);
    send_request(CMD_LOCK_SHARED, 6, 15);
  endtask

  task automatic test_count_saturation();
    send_request(CMD_UNLOCK_EXCL, 0, NUM_SLOTS);
    repeat (COUNT_TOP + 3) send_request(CMD_LOCK_SHARED, 0, $urandom_range(1, NUM_SLOTS));
    send_request(CMD_LOCK_EXCL, 0, 1);
    repeat (COUNT_TOP + 1) send_request(CMD_UNLOCK_SHARED, 0, NUM_SLOTS);
    send_request(CMD_LOCK_EXCL, 0, NUM_SLOTS);
    send_request(CMD_UNLOCK_EXCL, 0, NUM_SLOTS);
  endtask

  task automatic test_random_traffic(int n_items);
    int   first;
    int   n;
    int   pick;
    cmd_t c;
    repeat (n_items) begin
      pick = $urandom_range(0, 99);
      c = (pick < 30) ? CMD_LOCK_SHARED :
          (pick < 50) ? CMD_LOCK_EXCL :
          (pick < 80) ? CMD_UNLOCK_SHARED : CMD_UNLOCK_EXCL;
      first = $urandom_range(0, NUM_SLOTS - 1);
      pick = $urandom_range(0, 99);
      if (pick < 85) n = $urandom_range(1, NUM_SLOTS - first);
      else if (pick < 90) n = 0;
      else n = $urandom_range(0, 15);
      send_request(c, first, n);
    end
  endtask

  initial begin
    foreach (holder_count[i]) begin
      holder_count[i] = '0;
      excl_mark[i]    = 1'b0;
    end
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct  = 8;
    recv_stall_pct = 52;
    test_directed();
    test_random_traffic(350);

    send_idle_pct  = 52;
    recv_stall_pct = 8;
    test_count_saturation();

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_random_traffic(400);

    in_valid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### sim.f
rtl/srlt_pkg.sv
rtl/srlt_slot_array.sv
rtl/shared_exclusive_range_lock_table.sv
tb/tb.sv
